// ----- rtl/core/smo_pkg.sv -----
// Shared types, constants and helper functions of the sliding-mode observer.
package smo_pkg;

    localparam int SINE_DEPTH_DEF = 256;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] TURN_PER_RAD_Q16 = 64'd44798133900175;

    localparam logic signed [63:0] AMPS_LIMIT  = 64'sd13107200;
    localparam logic signed [63:0] PLL_LIMIT   = 64'sd327680000;
    localparam logic signed [63:0] DELTA_LIMIT = 64'sd1099511627776;
    localparam logic signed [63:0] INT32_MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] INT32_MIN64 = -64'sd2147483648;

    localparam logic [7:0] TAYLOR_DIV [7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_SWITCH_GAIN = 3'd0;
    localparam logic [2:0] CFG_BEMF_COEFF  = 3'd1;
    localparam logic [2:0] CFG_BOUNDARY    = 3'd2;
    localparam logic [2:0] CFG_PROP_GAIN   = 3'd3;
    localparam logic [2:0] CFG_INT_GAIN    = 3'd4;
    localparam logic [2:0] CFG_RESISTANCE  = 3'd5;
    localparam logic [2:0] CFG_INDUCTANCE  = 3'd6;
    localparam logic [2:0] CFG_STEP_TIME   = 3'd7;

    typedef struct packed {
        logic signed [31:0] volt_alpha;
        logic signed [31:0] volt_beta;
        logic signed [31:0] amps_alpha;
        logic signed [31:0] amps_beta;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        rotor_angle;
        logic signed [31:0] rotor_speed;
    } t_out_item;

    typedef struct packed {
        logic [39:0] switch_gain;
        logic [15:0] bemf_filter_coeff;
        logic [31:0] sigmoid_boundary;
        logic [39:0] pll_prop_gain;
        logic [39:0] pll_int_gain;
        logic [31:0] stator_resistance;
        logic [31:0] stator_inductance;
        logic [31:0] step_time;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        switch_gain:       40'd0,
        bemf_filter_coeff: 16'd1311,
        sigmoid_boundary:  32'd655,
        pll_prop_gain:     40'd26214400,
        pll_int_gain:      40'd2621440000,
        stator_resistance: 32'd0,
        stator_inductance: 32'd4294967,
        step_time:         32'd214748
    };

    typedef enum logic [1:0] {SH16, SH32, SH48} t_shift;

    typedef enum logic [1:0] {TS_IDLE, TS_LANE, TS_PLL, TS_PUT} t_top_state;

    typedef enum logic [2:0] {
        LS_IDLE, LS_SIG, LS_ZR, LS_RS, LS_RAT, LS_DA, LS_UPD
    } t_lane_state;

    typedef enum logic [3:0] {
        PS_IDLE, PS_TAB, PS_PA, PS_PB, PS_ERR, PS_KI, PS_DT, PS_KP, PS_OM, PS_ANG
    } t_pll_state;

    function automatic logic signed [63:0] f_clamp64(input logic signed [63:0] v,
                                                     input logic signed [63:0] lo,
                                                     input logic signed [63:0] hi);
        logic signed [63:0] r;
        r = v;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        return r;
    endfunction

    // Quarter-wave sine entry in Q1.16 from an angle x in Q30 radians (Taylor series).
    function automatic logic [16:0] f_sine_q16(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n - 1]);
            if (n % 2 == 1) sum = sum - signed'(term);
            else sum = sum + signed'(term);
        end
        if (sum < 0) sum = '0;
        sum = (sum + 64'sd8192) >>> 14;
        if (sum > 64'sd65536) sum = 64'sd65536;
        return 17'(sum);
    endfunction

endpackage

// ----- rtl/core/sliding_mode_bemf_observer_pll_top.sv -----
// Top level of the sliding-mode back-EMF observer with tracking loop.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+----------------------------
//  in      | sink      | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out     | source    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// From transfer to result, each lane runs a 64-step sigmoid division, then two multiplies
// overlapped with the 64-step ratio division and one more multiply; the merging stage then
// reads the table, forms the products and runs five multiplies in series; the result is
// then loaded into the output register.
// One sample is in work at a time; the next is taken as the result appears.
// Reset is synchronous and leaves all estimates at zero; there is no clearing pass.
// A result waiting in the output register does not stop the next input transfer.
module sliding_mode_bemf_observer_pll_top
    import smo_pkg::*;
#(
    parameter int SINE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [39:0] i_cfg_data
);

    t_top_state r_state, n_state;

    t_cfg       r_cfg;
    t_out_item  r_out;
    logic       r_out_valid;

    logic               w_lane_start;
    logic               w_pll_start;
    logic               w_load;
    logic signed [31:0] w_bemf_a;
    logic signed [31:0] w_bemf_b;
    logic               w_done_a;
    logic               w_done_b;
    logic [15:0]        w_angle;
    logic signed [31:0] w_speed;
    logic               w_pll_done;

    smo_lane u_lane_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_start (w_lane_start),
        .i_volt  (i_in_data.volt_alpha),
        .i_amps  (i_in_data.amps_alpha),
        .o_bemf  (w_bemf_a),
        .o_done  (w_done_a)
    );

    smo_lane u_lane_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_start (w_lane_start),
        .i_volt  (i_in_data.volt_beta),
        .i_amps  (i_in_data.amps_beta),
        .o_bemf  (w_bemf_b),
        .o_done  (w_done_b)
    );

    smo_pll #(
        .SINE_DEPTH (SINE_DEPTH)
    ) u_pll (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_start  (w_pll_start),
        .i_bemf_a (w_bemf_a),
        .i_bemf_b (w_bemf_b),
        .o_angle  (w_angle),
        .o_speed  (w_speed),
        .o_done   (w_pll_done)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE: if (i_in_valid) n_state = TS_LANE;
            TS_LANE: if (w_done_a && w_done_b) n_state = TS_PLL;
            TS_PLL:  if (w_pll_done) n_state = TS_PUT;
            TS_PUT:  if (!r_out_valid || i_out_ready) n_state = TS_IDLE;
            default: n_state = TS_IDLE;
        endcase
    end

    always_comb begin
        w_lane_start = 1'b0;
        w_pll_start  = 1'b0;
        w_load       = 1'b0;
        unique case (r_state)
            TS_IDLE: w_lane_start = i_in_valid;
            // Both lanes run in lock step and finish in the same cycle.
            TS_LANE: w_pll_start = w_done_a && w_done_b;
            TS_PUT:  w_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TS_IDLE;
            r_out_valid <= 1'b0;
            r_cfg       <= CFG_RESET;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid       <= 1'b1;
                r_out.rotor_angle <= w_angle;
                r_out.rotor_speed <= w_speed;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SWITCH_GAIN: r_cfg.switch_gain       <= i_cfg_data;
                    CFG_BEMF_COEFF:  r_cfg.bemf_filter_coeff <= i_cfg_data[15:0];
                    CFG_BOUNDARY:    r_cfg.sigmoid_boundary  <= i_cfg_data[31:0];
                    CFG_PROP_GAIN:   r_cfg.pll_prop_gain     <= i_cfg_data;
                    CFG_INT_GAIN:    r_cfg.pll_int_gain      <= i_cfg_data;
                    CFG_RESISTANCE:  r_cfg.stator_resistance <= i_cfg_data[31:0];
                    CFG_INDUCTANCE:  r_cfg.stator_inductance <= i_cfg_data[31:0];
                    CFG_STEP_TIME:   r_cfg.step_time         <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_in_ready  = (r_state == TS_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/smo_mulsh.sv -----
// Multi-cycle signed by unsigned 64x64 multiply with floor shift and saturation.
module smo_mulsh
    import smo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic [63:0]        i_b,
    input  t_shift             i_sh,
    output logic               o_busy,
    output logic signed [63:0] o_res
);

    logic               r_busy;
    logic [2:0]         r_cnt;
    logic [63:0]        r_mag;
    logic [63:0]        r_b;
    logic               r_neg;
    t_shift             r_sh;
    logic [63:0]        r_pp;
    logic [127:0]       r_acc;
    logic signed [63:0] r_res;

    logic [31:0]        w_pa;
    logic [31:0]        w_pb;
    logic [127:0]       w_add;
    logic [63:0]        w_q;
    logic [63:0]        w_q1;
    logic               w_hi;
    logic               w_rem;
    logic signed [63:0] w_fin;

    // Partial products in order: al*bl, al*bh, ah*bl, ah*bh.
    assign w_pa = r_cnt[1] ? r_mag[63:32] : r_mag[31:0];
    assign w_pb = r_cnt[0] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        case (r_cnt) inside
            3'd1:       w_add = {64'd0, r_pp};
            3'd2, 3'd3: w_add = {32'd0, r_pp, 32'd0};
            3'd4:       w_add = {r_pp, 64'd0};
            default:    w_add = '0;
        endcase
    end

    always_comb begin
        case (r_sh)
            SH32: begin
                w_q   = r_acc[95:32];
                w_hi  = |r_acc[127:96];
                w_rem = |r_acc[31:0];
            end
            SH48: begin
                w_q   = r_acc[111:48];
                w_hi  = |r_acc[127:112];
                w_rem = |r_acc[47:0];
            end
            default: begin
                w_q   = r_acc[79:16];
                w_hi  = |r_acc[127:80];
                w_rem = |r_acc[15:0];
            end
        endcase
        w_q1 = w_q + 64'(w_rem);
        if (!r_neg) begin
            w_fin = (w_hi || w_q[63]) ? 64'sh7FFF_FFFF_FFFF_FFFF : signed'(w_q);
        end else begin
            // Negative results round toward minus infinity.
            w_fin = (w_hi || w_q[63] || w_q1[63]) ? 64'sh8000_0000_0000_0000
                                                  : signed'(64'd0 - w_q1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_mag  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_neg  <= i_a[63];
            r_b    <= i_b;
            r_sh   <= i_sh;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            r_pp  <= 64'(w_pa) * 64'(w_pb);
            r_acc <= r_acc + w_add;
            if (r_cnt == 3'd5) begin
                r_res  <= w_fin;
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_res;

endmodule

// ----- rtl/core/smo_div.sv -----
// Restoring radix-2 divider, 64-bit unsigned, one quotient bit per cycle.
module smo_div
    import smo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_busy,
    output logic [63:0] o_quo
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [63:0] r_rem;

    logic [64:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_num[63]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            // The numerator register fills with quotient bits from the bottom.
            r_rem <= w_ge ? 64'(w_trial - {1'b0, r_den}) : 64'(w_trial);
            r_num <= {r_num[62:0], w_ge};
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;

endmodule

// ----- rtl/core/smo_lane.sv -----
// One observer lane: sigmoid switching term, current model step and back-EMF filter.
module smo_lane
    import smo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_start,
    input  logic signed [31:0] i_volt,
    input  logic signed [31:0] i_amps,
    output logic signed [31:0] o_bemf,
    output logic               o_done
);

    t_lane_state r_state, n_state;

    logic signed [31:0] r_volt;
    logic signed [31:0] r_est;
    logic signed [31:0] r_bemf;
    logic               r_neg;
    logic               r_den_zero;
    logic signed [41:0] r_z;
    logic signed [41:0] r_rsi;
    logic signed [41:0] r_da;
    logic signed [58:0] r_lp_prod;
    logic               r_done;

    logic               w_div_start;
    logic [63:0]        w_div_num;
    logic [63:0]        w_div_den;
    logic               w_div_busy;
    logic [63:0]        w_div_quo;
    logic               w_mul_start;
    logic signed [63:0] w_mul_a;
    logic [63:0]        w_mul_b;
    t_shift             w_mul_sh;
    logic               w_mul_busy;
    logic signed [63:0] w_mul_res;

    logic signed [33:0] w_err;
    logic [32:0]        w_mag;
    logic signed [17:0] w_sig_mag;
    logic signed [17:0] w_sig;
    logic [63:0]        w_ratio;
    logic signed [43:0] w_na;
    logic signed [42:0] w_est_sum;
    logic signed [42:0] w_d;
    logic signed [59:0] w_lp_sum;
    logic signed [43:0] w_lp_sh;

    assign w_err = 34'(r_est) - 34'(i_amps);
    assign w_mag = w_err[33] ? 33'(-w_err) : 33'(w_err);

    assign w_sig_mag = signed'({1'b0, w_div_quo[16:0]});
    assign w_sig     = r_den_zero ? '0 : (r_neg ? -w_sig_mag : w_sig_mag);

    // Zero inductance saturates the step ratio unless the period is zero too.
    assign w_ratio = (i_cfg.stator_inductance == '0)
                   ? ((i_cfg.step_time != '0) ? '1 : '0) : w_div_quo;

    assign w_na = 44'(r_volt) - 44'(r_rsi) - 44'(r_bemf) - 44'(r_z);

    assign w_est_sum = 43'(r_est) + 43'(r_da);
    assign w_d       = 43'(r_z) - 43'(r_bemf);
    assign w_lp_sum  = (60'(r_bemf) <<< 16) + 60'(r_lp_prod);
    assign w_lp_sh   = 44'(w_lp_sum >>> 16);

    smo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_div_quo)
    );

    smo_mulsh u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_sh    (w_mul_sh),
        .o_busy  (w_mul_busy),
        .o_res   (w_mul_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LS_IDLE: if (i_start) n_state = LS_SIG;
            LS_SIG:  if (!w_div_busy) n_state = LS_ZR;
            LS_ZR:   if (!w_mul_busy) n_state = LS_RS;
            LS_RS:   if (!w_mul_busy) n_state = LS_RAT;
            LS_RAT:  if (!w_div_busy) n_state = LS_DA;
            LS_DA:   if (!w_mul_busy) n_state = LS_UPD;
            LS_UPD:  n_state = LS_IDLE;
            default: n_state = LS_IDLE;
        endcase
    end

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_mul_sh    = SH16;
        unique case (r_state)
            LS_IDLE: begin
                w_div_start = i_start;
                w_div_num   = 64'({w_mag, 16'd0});
                w_div_den   = 64'(w_mag) + 64'(i_cfg.sigmoid_boundary);
            end
            LS_SIG: begin
                // The step ratio division runs while the multiplier works.
                w_div_start = !w_div_busy;
                w_div_num   = {i_cfg.step_time, 32'd0};
                w_div_den   = 64'(i_cfg.stator_inductance);
                w_mul_start = !w_div_busy;
                w_mul_a     = 64'(w_sig);
                w_mul_b     = 64'(i_cfg.switch_gain);
            end
            LS_ZR: begin
                w_mul_start = !w_mul_busy;
                w_mul_a     = 64'(r_est);
                w_mul_b     = 64'(i_cfg.stator_resistance);
            end
            LS_RAT: begin
                w_mul_start = !w_div_busy;
                w_mul_a     = 64'(w_na);
                w_mul_b     = w_ratio;
                w_mul_sh    = SH32;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_est   <= '0;
            r_bemf  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == LS_UPD);
            case (r_state)
                LS_IDLE: if (i_start) begin
                    r_volt     <= i_volt;
                    r_neg      <= w_err[33];
                    r_den_zero <= (w_mag == '0) && (i_cfg.sigmoid_boundary == '0);
                end
                LS_ZR: if (!w_mul_busy) r_z <= 42'(w_mul_res);
                LS_RS: begin
                    r_lp_prod <= 59'(signed'({1'b0, i_cfg.bemf_filter_coeff})) * 59'(w_d);
                    if (!w_mul_busy) r_rsi <= 42'(w_mul_res);
                end
                LS_DA: if (!w_mul_busy) begin
                    r_da <= 42'(f_clamp64(w_mul_res, -DELTA_LIMIT, DELTA_LIMIT));
                end
                LS_UPD: begin
                    r_est  <= 32'(f_clamp64(64'(w_est_sum), -AMPS_LIMIT, AMPS_LIMIT));
                    r_bemf <= 32'(f_clamp64(64'(w_lp_sh), INT32_MIN64, INT32_MAX64));
                end
                default: ;
            endcase
        end
    end

    assign o_bemf = r_bemf;
    assign o_done = r_done;

endmodule

// ----- rtl/core/smo_pll.sv -----
// Merging stage: phase detector on both back-EMF lanes, PI tracking loop and angle.
module smo_pll
    import smo_pkg::*;
#(
    parameter int SINE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_start,
    input  logic signed [31:0] i_bemf_a,
    input  logic signed [31:0] i_bemf_b,
    output logic [15:0]        o_angle,
    output logic signed [31:0] o_speed,
    output logic               o_done
);

    localparam int IW = $clog2(SINE_DEPTH + 1);

    t_pll_state r_state, n_state;

    logic [31:0]        r_angle;
    logic signed [31:0] r_pll;
    logic signed [31:0] r_omega;
    logic signed [31:0] r_ba;
    logic signed [31:0] r_bb;
    logic [IW-1:0]      r_idx;
    logic [1:0]         r_quad;
    logic signed [17:0] r_sn;
    logic signed [17:0] r_cs;
    logic signed [49:0] r_pa;
    logic signed [49:0] r_pb;
    logic signed [35:0] r_perr;
    logic signed [63:0] r_inc;
    logic               r_done;

    logic [16:0]        w_sine [SINE_DEPTH + 1];
    logic [29+IW:0]     w_idx_prod;
    logic signed [17:0] w_ta;
    logic signed [17:0] w_tb;
    logic signed [17:0] w_sn;
    logic signed [17:0] w_cs;
    logic signed [50:0] w_psum;
    logic signed [51:0] w_pneg;
    logic signed [35:0] w_perr;
    logic signed [31:0] w_pll_new;
    logic signed [31:0] w_omega;

    logic               w_mul_start;
    logic signed [63:0] w_mul_a;
    logic [63:0]        w_mul_b;
    t_shift             w_mul_sh;
    logic               w_mul_busy;
    logic signed [63:0] w_mul_res;

    for (genvar k = 0; k <= SINE_DEPTH; k++) begin : g_sine
        localparam logic [63:0] X = (PI_HALF_Q30 * 64'(k)) / 64'(SINE_DEPTH);
        assign w_sine[k] = f_sine_q16(X);
    end

    assign w_idx_prod = (30 + IW)'(r_angle[29:0]) * (30 + IW)'(SINE_DEPTH);
    assign w_ta = signed'({1'b0, w_sine[r_idx]});
    assign w_tb = signed'({1'b0, w_sine[IW'(SINE_DEPTH) - r_idx]});

    always_comb begin
        case (r_quad)
            2'd0: begin w_sn = w_ta;  w_cs = w_tb;  end
            2'd1: begin w_sn = w_tb;  w_cs = -w_ta; end
            2'd2: begin w_sn = -w_ta; w_cs = -w_tb; end
            default: begin w_sn = -w_tb; w_cs = w_ta; end
        endcase
    end

    assign w_psum = 51'(r_pa) + 51'(r_pb);
    assign w_pneg = -52'(w_psum);
    assign w_perr = 36'(w_pneg >>> 16);

    assign w_pll_new = 32'(f_clamp64(64'(r_pll) + r_inc, -PLL_LIMIT, PLL_LIMIT));
    assign w_omega   = 32'(f_clamp64(64'(w_pll_new) + w_mul_res, INT32_MIN64, INT32_MAX64));

    smo_mulsh u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_sh    (w_mul_sh),
        .o_busy  (w_mul_busy),
        .o_res   (w_mul_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            PS_IDLE: if (i_start) n_state = PS_TAB;
            PS_TAB:  n_state = PS_PA;
            PS_PA:   n_state = PS_PB;
            PS_PB:   n_state = PS_ERR;
            PS_ERR:  n_state = PS_KI;
            PS_KI:   if (!w_mul_busy) n_state = PS_DT;
            PS_DT:   if (!w_mul_busy) n_state = PS_KP;
            PS_KP:   if (!w_mul_busy) n_state = PS_OM;
            PS_OM:   if (!w_mul_busy) n_state = PS_ANG;
            PS_ANG:  if (!w_mul_busy) n_state = PS_IDLE;
            default: n_state = PS_IDLE;
        endcase
    end

    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_mul_sh    = SH16;
        unique case (r_state)
            PS_ERR: begin
                w_mul_start = 1'b1;
                w_mul_a     = 64'(w_perr);
                w_mul_b     = 64'(i_cfg.pll_int_gain);
            end
            PS_KI: begin
                w_mul_start = !w_mul_busy;
                w_mul_a     = w_mul_res;
                w_mul_b     = 64'(i_cfg.step_time);
                w_mul_sh    = SH32;
            end
            PS_DT: begin
                w_mul_start = !w_mul_busy;
                w_mul_a     = 64'(r_perr);
                w_mul_b     = 64'(i_cfg.pll_prop_gain);
            end
            PS_KP: begin
                w_mul_start = !w_mul_busy;
                w_mul_a     = 64'(w_omega);
                w_mul_b     = 64'(i_cfg.step_time);
            end
            PS_OM: begin
                w_mul_start = !w_mul_busy;
                w_mul_a     = w_mul_res;
                w_mul_b     = TURN_PER_RAD_Q16;
                w_mul_sh    = SH48;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_IDLE;
            r_angle <= '0;
            r_pll   <= '0;
            r_omega <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == PS_ANG) && !w_mul_busy;
            case (r_state)
                PS_IDLE: if (i_start) begin
                    // The table is read with the angle from before this update.
                    r_ba   <= i_bemf_a;
                    r_bb   <= i_bemf_b;
                    r_idx  <= w_idx_prod[29+IW:30];
                    r_quad <= r_angle[31:30];
                end
                PS_TAB: begin
                    r_sn <= w_sn;
                    r_cs <= w_cs;
                end
                PS_PA:  r_pa <= 50'(r_ba) * 50'(r_cs);
                PS_PB:  r_pb <= 50'(r_bb) * 50'(r_sn);
                PS_ERR: r_perr <= w_perr;
                PS_DT:  if (!w_mul_busy) r_inc <= w_mul_res;
                PS_KP:  if (!w_mul_busy) begin
                    r_pll   <= w_pll_new;
                    r_omega <= w_omega;
                end
                PS_ANG: if (!w_mul_busy) r_angle <= r_angle + w_mul_res[31:0];
                default: ;
            endcase
        end
    end

    assign o_angle = r_angle[31:16];
    assign o_speed = r_omega;
    assign o_done  = r_done;

endmodule

// ----- rtl/core/smo_checker.sv -----
// Port-level checks of the observer top level, bound to every instance.
module smo_checker
    import smo_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // After a transfer in, the block is busy with that sample.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again right after a transfer");

    // A result appears only as the sequencer returns to idle.
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result raised while a sample is still in work");

    // A stalled result is held with its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after reset");

endmodule

bind sliding_mode_bemf_observer_pll_top smo_checker u_smo_checker (.*);
